/* hw/rtl/vrip_pkg.sv */
package vrip_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;

  localparam int GAIN_W  = 32;
  localparam int LIMIT_W = 31;
  localparam int BAND_W  = 30;

  localparam int ERR_W  = VALUE_WIDTH + 1;
  localparam int DIFF_W = VALUE_WIDTH + 2;
  localparam int TERM_W = VALUE_WIDTH + 4;
  localparam int SUM_W  = TERM_W + 2;

  localparam int MULA_W  = TERM_W;
  localparam int SLICE_W = (DIFF_W + 1) / 2;
  localparam int MULP_W  = MULA_W + SLICE_W;
  localparam int PROD_W  = MULA_W + 2 * SLICE_W;
  localparam int QUO_W   = TERM_W - 1;
  localparam int CNT_W   = $clog2(QUO_W);

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  localparam logic [PROD_W-1:0] TERM_MAX =
    PROD_W'((65'd1 << (TERM_W - 1)) - 65'd1);
  localparam logic signed [SUM_W-1:0] VAL_MAX =
    SUM_W'((65'd1 << (VALUE_WIDTH - 1)) - 65'd1);
  localparam logic signed [SUM_W-1:0] VAL_MIN = -VAL_MAX - SUM_W'(1);

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_INTEGRAL_LIMIT,
    REG_BAND_A,
    REG_BAND_B
  } reg_idx_t;

endpackage

/* hw/rtl/vrip_if.sv */
interface vrip_in_if import vrip_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [VALUE_WIDTH-1:0] setpoint;
  logic signed [VALUE_WIDTH-1:0] measurement;

  modport source (output valid, cmd, setpoint, measurement, input ready);
  modport sink (input valid, cmd, setpoint, measurement, output ready);
endinterface

interface vrip_out_if import vrip_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] drive;
  logic signed [VALUE_WIDTH-1:0] integral_now;
  logic                          saturated;

  modport source (output valid, drive, integral_now, saturated, input ready);
  modport sink (input valid, drive, integral_now, saturated, output ready);
endinterface

/* hw/rtl/variable_rate_integral_pid_top.sv */
// Positional PID controller with variable-rate integration, Q16.16.
// in_chan carries one request: cmd (0 = control step, 1 = clear), setpoint
// and measurement. out_chan returns one result per request: drive,
// integral_now and saturated. Both channels move a request when valid and
// ready are high at a rising edge of clk.
// Gains, integral limit and taper bands are written over the APB-style cfg_
// port (byte address 4*i, pready always high); the user must write them
// only while the block is idle, which the block itself does not enforce.
// A control step runs S_DIFF; S_MUL_LO, S_MUL_HI, S_TERM for the I term;
// S_INTEG; the same three for the P, then the D term; S_SUM; S_DONE, which
// loads the output register. A taper-band increment adds a taper product
// and the 35-step bit-serial divider before S_INTEG; a clear goes to S_DONE.
// The three gain products and the taper product share one 36x17 multiplier,
// two passes per product, so requests are processed one at a time and
// in_chan.ready is high only while the sequencer is idle.
// One finished result may wait in the output register while the next
// request is accepted; if the receiver still stalls when that request is
// done, the sequencer holds it until the output register is free.
// rst_n (synchronous, active low) clears the stored error and integral,
// drops any pending result and restores the register reset values.
module variable_rate_integral_pid_top import vrip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vrip_in_if.sink           in_chan,
  vrip_out_if.source        out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL_LO, S_MUL_HI, S_TERM, S_DIV_LOAD, S_DIV, S_QUO,
    S_INTEG, S_SUM, S_DONE
  } state_t;

  typedef enum logic [1:0] {TS_I, TS_TAPER, TS_P, TS_D} term_sel_t;

  function automatic logic [DIFF_W-1:0] mag_of(input logic signed [DIFF_W-1:0] x);
    return x[DIFF_W-1] ? DIFF_W'(-x) : DIFF_W'(x);
  endfunction

  state_t                      state_r, state_nxt;
  term_sel_t                   sel_r, sel_nxt;
  logic signed [GAIN_W-1:0]    gain_p_r, gain_p_nxt;
  logic signed [GAIN_W-1:0]    gain_i_r, gain_i_nxt;
  logic signed [GAIN_W-1:0]    gain_d_r, gain_d_nxt;
  logic [LIMIT_W-1:0]          ilim_r, ilim_nxt;
  logic [BAND_W-1:0]           band_a_r, band_a_nxt;
  logic [BAND_W-1:0]           band_b_r, band_b_nxt;
  logic signed [ERR_W-1:0]     err_r, err_nxt;
  logic signed [ERR_W-1:0]     prev_err_r, prev_err_nxt;
  logic signed [DIFF_W-1:0]    diff_r, diff_nxt;
  logic [MULA_W-1:0]           mul_a_r, mul_a_nxt;
  logic [DIFF_W-1:0]           mul_b_r, mul_b_nxt;
  logic                        mul_neg_r, mul_neg_nxt;
  logic [PROD_W-1:0]           prod_r, prod_nxt;
  logic signed [TERM_W-1:0]    inc_r, inc_nxt;
  logic signed [TERM_W-1:0]    p_r, p_nxt;
  logic signed [TERM_W-1:0]    d_r, d_nxt;
  logic signed [VALUE_WIDTH-1:0] integ_r, integ_nxt;
  logic [QUO_W-1:0]            div_num_r, div_num_nxt;
  logic [BAND_W-1:0]           rem_r, rem_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic signed [VALUE_WIDTH-1:0] res_drive_r, res_drive_nxt;
  logic signed [VALUE_WIDTH-1:0] res_integ_r, res_integ_nxt;
  logic                        res_sat_r, res_sat_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] out_drive_r, out_drive_nxt;
  logic signed [VALUE_WIDTH-1:0] out_integ_r, out_integ_nxt;
  logic                        out_sat_r, out_sat_nxt;

  logic [SLICE_W-1:0]          slice;
  logic [MULP_W-1:0]           pp;
  logic [PROD_W-1:0]           shifted;
  logic [TERM_W-1:0]           term_mag;
  logic signed [TERM_W-1:0]    term;
  logic [ERR_W-1:0]            abs_err;
  logic [BAND_W:0]             band_sum;
  logic                        same_sign;
  logic [BAND_W:0]             rem2;
  logic                        div_ge;
  logic signed [SUM_W-1:0]     lim_s, isum, total;
  logic                        cfg_wr;

  assign slice = (state_r == S_MUL_HI) ? mul_b_r[DIFF_W-1:SLICE_W] : mul_b_r[SLICE_W-1:0];
  assign pp    = mul_a_r * slice;

  assign shifted  = prod_r >> FRACTION_BITS;
  assign term_mag = (shifted > TERM_MAX) ? TERM_MAX[TERM_W-1:0] : shifted[TERM_W-1:0];
  assign term     = mul_neg_r ? -$signed(term_mag) : $signed(term_mag);

  assign abs_err   = ERR_W'(mag_of(DIFF_W'(err_r)));
  assign band_sum  = {1'b0, band_a_r} + {1'b0, band_b_r};
  assign same_sign = (err_r > 0 && integ_r > 0) || (err_r < 0 && integ_r < 0);

  assign rem2   = {rem_r, div_num_r[QUO_W-1]};
  assign div_ge = rem2 >= {1'b0, band_a_r};

  assign lim_s = ($signed(SUM_W'(ilim_r)) > VAL_MAX) ? VAL_MAX : $signed(SUM_W'(ilim_r));
  assign isum  = SUM_W'(integ_r) + SUM_W'(inc_r);
  assign total = SUM_W'(p_r) + SUM_W'(integ_r) + SUM_W'(d_r);

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_GAIN_P:         cfg_prdata = DATA_W'(gain_p_r);
      REG_GAIN_I:         cfg_prdata = DATA_W'(gain_i_r);
      REG_GAIN_D:         cfg_prdata = DATA_W'(gain_d_r);
      REG_INTEGRAL_LIMIT: cfg_prdata = DATA_W'(ilim_r);
      REG_BAND_A:         cfg_prdata = DATA_W'(band_a_r);
      REG_BAND_B:         cfg_prdata = DATA_W'(band_b_r);
      default:            cfg_prdata = '0;
    endcase
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.drive        = out_drive_r;
  assign out_chan.integral_now = out_integ_r;
  assign out_chan.saturated    = out_sat_r;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    ilim_nxt      = ilim_r;
    band_a_nxt    = band_a_r;
    band_b_nxt    = band_b_r;
    err_nxt       = err_r;
    prev_err_nxt  = prev_err_r;
    diff_nxt      = diff_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_neg_nxt   = mul_neg_r;
    prod_nxt      = prod_r;
    inc_nxt       = inc_r;
    p_nxt         = p_r;
    d_nxt         = d_r;
    integ_nxt     = integ_r;
    div_num_nxt   = div_num_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_drive_nxt = res_drive_r;
    res_integ_nxt = res_integ_r;
    res_sat_nxt   = res_sat_r;
    out_valid_nxt = out_valid_r;
    out_drive_nxt = out_drive_r;
    out_integ_nxt = out_integ_r;
    out_sat_nxt   = out_sat_r;

    if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[4:2]))
        REG_GAIN_P:         gain_p_nxt = $signed(cfg_pwdata[GAIN_W-1:0]);
        REG_GAIN_I:         gain_i_nxt = $signed(cfg_pwdata[GAIN_W-1:0]);
        REG_GAIN_D:         gain_d_nxt = $signed(cfg_pwdata[GAIN_W-1:0]);
        REG_INTEGRAL_LIMIT: ilim_nxt   = cfg_pwdata[LIMIT_W-1:0];
        REG_BAND_A:         band_a_nxt = cfg_pwdata[BAND_W-1:0];
        REG_BAND_B:         band_b_nxt = cfg_pwdata[BAND_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          if (in_chan.cmd) begin
            prev_err_nxt  = '0;
            integ_nxt     = '0;
            res_drive_nxt = '0;
            res_integ_nxt = '0;
            res_sat_nxt   = 1'b0;
            state_nxt     = S_DONE;
          end else begin
            err_nxt   = ERR_W'(in_chan.setpoint) - ERR_W'(in_chan.measurement);
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        diff_nxt    = DIFF_W'(err_r) - DIFF_W'(prev_err_r);
        mul_a_nxt   = MULA_W'(mag_of(DIFF_W'(gain_i_r)));
        mul_b_nxt   = mag_of(DIFF_W'(err_r));
        mul_neg_nxt = gain_i_r[GAIN_W-1] ^ err_r[ERR_W-1];
        sel_nxt     = TS_I;
        state_nxt   = S_MUL_LO;
      end
      S_MUL_LO: begin
        prod_nxt  = PROD_W'(pp);
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        prod_nxt  = prod_r + (PROD_W'(pp) << SLICE_W);
        state_nxt = (sel_r == TS_TAPER) ? S_DIV_LOAD : S_TERM;
      end
      S_TERM: begin
        case (sel_r)
          TS_I: begin
            inc_nxt   = term;
            state_nxt = S_INTEG;
            if (same_sign) begin
              if (abs_err > ERR_W'(band_sum)) begin
                inc_nxt = '0;
              end else if (abs_err > ERR_W'(band_b_r)) begin
                mul_a_nxt = MULA_W'(term_mag);
                mul_b_nxt = DIFF_W'(band_sum - abs_err[BAND_W:0]);
                sel_nxt   = TS_TAPER;
                state_nxt = S_MUL_LO;
              end
            end
          end
          TS_P: begin
            p_nxt       = term;
            mul_a_nxt   = MULA_W'(mag_of(DIFF_W'(gain_d_r)));
            mul_b_nxt   = mag_of(diff_r);
            mul_neg_nxt = gain_d_r[GAIN_W-1] ^ diff_r[DIFF_W-1];
            sel_nxt     = TS_D;
            state_nxt   = S_MUL_LO;
          end
          TS_D: begin
            d_nxt        = term;
            prev_err_nxt = err_r;
            state_nxt    = S_SUM;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV_LOAD: begin
        rem_nxt     = prod_r[QUO_W+BAND_W-1:QUO_W];
        div_num_nxt = prod_r[QUO_W-1:0];
        cnt_nxt     = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        rem_nxt     = div_ge ? BAND_W'(rem2 - {1'b0, band_a_r}) : rem2[BAND_W-1:0];
        div_num_nxt = {div_num_r[QUO_W-2:0], div_ge};
        cnt_nxt     = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          state_nxt = S_QUO;
        end
      end
      S_QUO: begin
        inc_nxt   = mul_neg_r ? -$signed(TERM_W'(div_num_r)) : $signed(TERM_W'(div_num_r));
        state_nxt = S_INTEG;
      end
      S_INTEG: begin
        if (isum > lim_s) begin
          integ_nxt = VALUE_WIDTH'(lim_s);
        end else if (isum < -lim_s) begin
          integ_nxt = VALUE_WIDTH'(-lim_s);
        end else begin
          integ_nxt = VALUE_WIDTH'(isum);
        end
        mul_a_nxt   = MULA_W'(mag_of(DIFF_W'(gain_p_r)));
        mul_b_nxt   = mag_of(DIFF_W'(err_r));
        mul_neg_nxt = gain_p_r[GAIN_W-1] ^ err_r[ERR_W-1];
        sel_nxt     = TS_P;
        state_nxt   = S_MUL_LO;
      end
      S_SUM: begin
        res_integ_nxt = integ_r;
        if (total > VAL_MAX) begin
          res_drive_nxt = VALUE_WIDTH'(VAL_MAX);
          res_sat_nxt   = 1'b1;
        end else if (total < VAL_MIN) begin
          res_drive_nxt = VALUE_WIDTH'(VAL_MIN);
          res_sat_nxt   = 1'b1;
        end else begin
          res_drive_nxt = VALUE_WIDTH'(total);
          res_sat_nxt   = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = res_drive_r;
          out_integ_nxt = res_integ_r;
          out_sat_nxt   = res_sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= TS_I;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      ilim_r      <= '1;
      band_a_r    <= '0;
      band_b_r    <= '0;
      prev_err_r  <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      ilim_r      <= ilim_nxt;
      band_a_r    <= band_a_nxt;
      band_b_r    <= band_b_nxt;
      prev_err_r  <= prev_err_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    err_r       <= err_nxt;
    diff_r      <= diff_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    mul_neg_r   <= mul_neg_nxt;
    prod_r      <= prod_nxt;
    inc_r       <= inc_nxt;
    p_r         <= p_nxt;
    d_r         <= d_nxt;
    div_num_r   <= div_num_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    res_drive_r <= res_drive_nxt;
    res_integ_r <= res_integ_nxt;
    res_sat_r   <= res_sat_nxt;
    out_drive_r <= out_drive_nxt;
    out_integ_r <= out_integ_nxt;
    out_sat_r   <= out_sat_nxt;
  end

endmodule
